@@ hw/rtl/lzd_pkg.sv @@
// Shared constants and types of the LZSS decompressor.
`timescale 1ns / 1ps
package lzd_pkg;

  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned WIN_AW     = $clog2(HIST_DEPTH);
  localparam int unsigned FILL_W     = WIN_AW + 1;

  localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(12'hFEE);
  localparam logic [4:0]        MIN_MATCH = 5'd3;

  // Index of each configuration register.
  localparam logic CFG_STOP_AT_LIMIT = 1'b0;
  localparam logic CFG_OUTPUT_LIMIT  = 1'b1;

  typedef struct packed {
    logic        stop_at_limit;
    logic [31:0] output_limit;
  } cfg_t;

  // Access to the history window for one cycle.
  typedef struct packed {
    logic              wr_en;
    logic [WIN_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [WIN_AW-1:0] rd_addr;
    logic              clr;
  } win_req_t;

  // One decompressed byte leaving the sequencer.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       run_last;
    logic       limit_reached;
  } beat_t;

endpackage

@@ hw/rtl/lzd_window.sv @@
// History window memory with a fill count that stands in for clearing.
`timescale 1ns / 1ps
module lzd_window (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lzd_pkg::win_req_t        req_i,
  output logic [7:0]               rd_data_o
);
  import lzd_pkg::*;

  logic [7:0]        mem [HIST_DEPTH];
  logic [7:0]        mem_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [WIN_AW-1:0] rel_addr;
  logic              zero_d, zero_q;
  logic              byp_d, byp_q;
  logic [7:0]        byp_data_q;

  // Writes always follow on from the start position, so an entry holds
  // data of this block exactly when its distance from there is below the fill.
  assign rel_addr = req_i.rd_addr - START_POS;
  assign zero_d   = ({1'b0, rel_addr} >= fill_q);
  assign byp_d    = req_i.wr_en && (req_i.wr_addr == req_i.rd_addr);

  always_comb begin
    fill_d = fill_q;
    if (req_i.clr) begin
      fill_d = '0;
    end else if (req_i.wr_en && (fill_q != FILL_W'(HIST_DEPTH))) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    mem_q      <= mem[req_i.rd_addr];
    zero_q     <= zero_d;
    byp_q      <= byp_d;
    byp_data_q <= req_i.wr_data;
  end

  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (zero_q) begin
      rd_data_o = 8'h00;
    end else begin
      rd_data_o = mem_q;
    end
  end

endmodule

@@ hw/rtl/lzd_ctrl.sv @@
// Stream parser and copy sequencer that emits one byte per cycle while the output can take one.
`timescale 1ns / 1ps
module lzd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lzd_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  logic                 emit_ok_i,
  output lzd_pkg::beat_t       beat_o,
  output lzd_pkg::win_req_t    win_o,
  input  logic [7:0]           win_data_i
);
  import lzd_pkg::*;

  typedef enum logic [1:0] {
    PH_FLAG   = 2'd0,
    PH_ITEM   = 2'd1,
    PH_MATCH2 = 2'd2
  } phase_e;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [8:0]        fs_q, fs_d;
  logic [7:0]        off_low_q, off_low_d;
  logic [WIN_AW-1:0] wp_q, wp_d;
  logic [31:0]       cnt_q, cnt_d;
  logic [WIN_AW-1:0] off_q, off_d;
  logic [4:0]        len_q, len_d;
  logic [4:0]        idx_q, idx_d;
  logic              last_q, last_d;

  logic        hit;
  logic        accept;
  logic [31:0] cnt_inc;
  logic        lim_eq;
  logic [4:0]  idx_inc;
  logic [8:0]  fs_shift;
  logic        consume;
  logic        blk_reset;
  logic        start_copy;

  assign hit        = cfg_i.stop_at_limit && (cnt_q >= cfg_i.output_limit);
  assign in_ready_o = (state_q == ST_IDLE) && emit_ok_i;
  assign accept     = in_ready_o && in_valid_i;
  assign cnt_inc    = cnt_q + 32'd1;
  assign lim_eq     = cfg_i.stop_at_limit && (cnt_inc == cfg_i.output_limit);
  assign idx_inc    = idx_q + 5'd1;
  assign fs_shift   = {1'b0, fs_q[8:1]};
  assign start_copy = accept && !hit && (phase_q == PH_MATCH2);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    fs_d      = fs_q;
    off_low_d = off_low_q;
    wp_d      = wp_q;
    cnt_d     = cnt_q;
    off_d     = off_q;
    len_d     = len_q;
    idx_d     = idx_q;
    last_d    = last_q;
    consume   = 1'b0;
    blk_reset = 1'b0;

    beat_o.valid         = 1'b0;
    beat_o.data          = win_data_i;
    beat_o.run_last      = 1'b0;
    beat_o.limit_reached = lim_eq;

    win_o.wr_en   = 1'b0;
    win_o.wr_addr = wp_q;
    win_o.wr_data = win_data_i;
    win_o.rd_addr = off_q + WIN_AW'(idx_q);
    win_o.clr     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!hit) begin
            case (phase_q)
              PH_ITEM: begin
                if (fs_q[0]) begin
                  beat_o.valid    = 1'b1;
                  beat_o.data     = in_byte_i;
                  beat_o.run_last = 1'b1;
                  win_o.wr_en     = 1'b1;
                  win_o.wr_data   = in_byte_i;
                  wp_d            = wp_q + WIN_AW'(1);
                  cnt_d           = cnt_inc;
                  consume         = 1'b1;
                end else begin
                  off_low_d = in_byte_i;
                  phase_d   = PH_MATCH2;
                end
              end
              PH_MATCH2: begin
                off_d         = {in_byte_i[7:4], off_low_q};
                len_d         = {1'b0, in_byte_i[3:0]} + MIN_MATCH;
                idx_d         = '0;
                last_d        = in_last_i;
                win_o.rd_addr = {in_byte_i[7:4], off_low_q};
                state_d       = ST_COPY;
              end
              default: begin
                fs_d    = {1'b1, in_byte_i};
                phase_d = PH_ITEM;
              end
            endcase
          end
          // A block ending on a match finishes its copy before resetting.
          if (in_last_i && !start_copy) begin
            blk_reset = 1'b1;
          end
        end
      end
      ST_COPY: begin
        if (emit_ok_i) begin
          beat_o.valid    = 1'b1;
          beat_o.run_last = (idx_inc == len_q) || lim_eq;
          win_o.wr_en     = 1'b1;
          wp_d            = wp_q + WIN_AW'(1);
          cnt_d           = cnt_inc;
          idx_d           = idx_inc;
          win_o.rd_addr   = off_q + WIN_AW'(idx_inc);
          if (beat_o.run_last) begin
            consume = 1'b1;
            state_d = ST_IDLE;
            if (last_q) begin
              blk_reset = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (consume) begin
      fs_d    = fs_shift;
      phase_d = (fs_shift <= 9'd1) ? PH_FLAG : PH_ITEM;
    end

    if (blk_reset) begin
      wp_d      = START_POS;
      fs_d      = '0;
      phase_d   = PH_FLAG;
      off_low_d = '0;
      cnt_d     = '0;
      win_o.clr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_FLAG;
      fs_q      <= '0;
      off_low_q <= '0;
      wp_q      <= START_POS;
      cnt_q     <= '0;
      off_q     <= '0;
      len_q     <= '0;
      idx_q     <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      fs_q      <= fs_d;
      off_low_q <= off_low_d;
      wp_q      <= wp_d;
      cnt_q     <= cnt_d;
      off_q     <= off_d;
      len_q     <= len_d;
      idx_q     <= idx_d;
      last_q    <= last_d;
    end
  end

endmodule

@@ hw/rtl/lzss_decompressor.sv @@
// LZSS decompressor top level: configuration, sequencer, window and output register.
// A flag byte or first match byte emits nothing; a literal shows on the output in the
// cycle after its transaction. A match copies 3 to 18 bytes, one byte per cycle, set by
// the single window read port, through the window's read register and the output register.
// Output back-pressure stalls the copy; the next input is taken once the copy ends.
// Reset clears all control state; the window needs no clearing pass, a fill count masks it.
`timescale 1ns / 1ps
module lzss_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] limit_reached
);
  import lzd_pkg::*;

  cfg_t       cfg_q;
  win_req_t   win_req;
  logic [7:0] win_data;
  beat_t      beat;
  logic       emit_ok;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_last_q;
  logic       out_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STOP_AT_LIMIT: cfg_q.stop_at_limit <= cfg_data_i[0];
        CFG_OUTPUT_LIMIT:  cfg_q.output_limit  <= cfg_data_i;
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // The output register takes a new byte whenever it is empty or being drained.
  assign emit_ok = !out_valid_q || m_axis_tready;

  lzd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .emit_ok_i  (emit_ok),
    .beat_o     (beat),
    .win_o      (win_req),
    .win_data_i (win_data)
  );

  lzd_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (win_req),
    .rd_data_o (win_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat.valid) begin
      out_data_q <= beat.data;
      out_last_q <= beat.run_last;
      out_lim_q  <= beat.limit_reached;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_lim_q;

  // A byte is never pushed into an output register that still holds an untaken one.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat.valid |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten");

  // Reaching the limit always ends the run of bytes for the current input.
  a_limit_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("limit reached without run end");

  // No input is taken in the cycle that a copy byte other than the last of its run is emitted.
  a_busy_during_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat.valid && !beat.run_last) |-> !s_axis_tready)
    else $error("input accepted during a copy");

endmodule
